>>> rtl/breath_phase_detector_macros.svh
// assertion macros shared by the breath phase detector rtl
`ifndef BREATH_PHASE_DETECTOR_MACROS_SVH
`define BREATH_PHASE_DETECTOR_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define BPD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpd same-cycle check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define BPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpd next-cycle check failed");

`endif

>>> rtl/bpd_pkg.sv
// shared types, constants and helpers of the breath phase detector
`timescale 1ns / 1ps

package bpd_pkg;

  localparam int unsigned SAMPLE_BITS      = 12;
  localparam int unsigned LEVEL_BITS       = 20;
  localparam int unsigned ALPHA_BITS       = 16;
  localparam int unsigned SLOPE_BITS       = 16;
  localparam int unsigned CFG_IDX_BITS     = 3;
  localparam int unsigned CFG_DATA_BITS    = 16;
  localparam int unsigned PHASE_BITS       = 2;
  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  localparam logic [ALPHA_BITS-1:0]  WEIGHT_EXHALED_RST = 16'd19661;
  localparam logic [ALPHA_BITS-1:0]  WEIGHT_OTHER_RST   = 16'd6554;
  localparam logic [SAMPLE_BITS-1:0] JUMP_LIMIT_RST     = 12'd300;
  localparam logic [SAMPLE_BITS-1:0] RISE_MARGIN_RST    = 12'd40;
  localparam logic [SLOPE_BITS-1:0]  SLOPE_FAST_RST     = 16'd1280;
  localparam logic [SLOPE_BITS-1:0]  SLOPE_SLOW_RST     = 16'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WEIGHT_EXHALED = 3'd0,
    CFG_WEIGHT_OTHER   = 3'd1,
    CFG_JUMP_LIMIT     = 3'd2,
    CFG_RISE_MARGIN    = 3'd3,
    CFG_SLOPE_FAST     = 3'd4,
    CFG_SLOPE_SLOW     = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_EXHALED  = 4'b0001,
    PH_INHALING = 4'b0010,
    PH_INHALED  = 4'b0100,
    PH_EXHALING = 4'b1000
  } phase_e;

  localparam logic [PHASE_BITS-1:0] PHASE_CODE_EXHALED  = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_INHALING = 2'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_INHALED  = 2'd2;
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_EXHALING = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   force_pump;
    logic                   breathe_pump;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [LEVEL_BITS-1:0]  smoothed;
    logic [PHASE_BITS-1:0]  phase;
    logic                   pump_on;
    logic                   inhale_start;
  } out_item_t;

  typedef struct packed {
    logic [ALPHA_BITS-1:0]  weight_exhaled;
    logic [ALPHA_BITS-1:0]  weight_other;
    logic [SAMPLE_BITS-1:0] jump_limit;
    logic [SAMPLE_BITS-1:0] rise_margin;
    logic [SLOPE_BITS-1:0]  slope_fast;
    logic [SLOPE_BITS-1:0]  slope_slow;
  } cfg_t;

  typedef struct packed {
    logic force_pump;
    logic breathe_pump;
  } cmd_t;

  function automatic logic [PHASE_BITS-1:0] phase_code(phase_e ph);
    logic [PHASE_BITS-1:0] code;
    case (ph)
      PH_EXHALED:  code = PHASE_CODE_EXHALED;
      PH_INHALING: code = PHASE_CODE_INHALING;
      PH_INHALED:  code = PHASE_CODE_INHALED;
      PH_EXHALING: code = PHASE_CODE_EXHALING;
      default:     code = PHASE_CODE_EXHALED;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/bpd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module bpd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bpd_window.sv
// spike rejection and boxcar window running sum
`timescale 1ns / 1ps

module bpd_window #(
  parameter int unsigned WINDOW_DEPTH = bpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   adv_i,
  input  logic [bpd_pkg::SAMPLE_BITS-1:0]                        sample_i,
  input  logic [bpd_pkg::SAMPLE_BITS-1:0]                        jump_limit_i,
  output logic [bpd_pkg::SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]   sum_o
);

  import bpd_pkg::*;

  localparam int unsigned LOG_D    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + LOG_D;
  localparam int unsigned FILL_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam logic [SUM_BITS-1:0]  DEPTH_S   = SUM_BITS'(WINDOW_DEPTH);
  localparam logic [LOG_D-1:0]     SLOT_LAST = LOG_D'(WINDOW_DEPTH - 1);
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW_DEPTH);

  logic [SAMPLE_BITS-1:0] last_valid_q, last_valid_d;
  logic [SAMPLE_BITS-1:0] prime_q, prime_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [LOG_D-1:0]       slot_q, slot_d;
  logic [FILL_BITS-1:0]   fill_q, fill_d;

  logic [SAMPLE_BITS-1:0] diff, clean, oldest, rd_data;
  logic [SUM_BITS-1:0]    sum_base;
  logic [LOG_D-1:0]       slot_inc, rd_addr;
  logic                   primed, unfilled, reject;

  assign primed   = (fill_q != '0);
  assign unfilled = (fill_q < FILL_FULL);

  // distance to the last accepted sample
  assign diff   = (sample_i >= last_valid_q) ? (sample_i - last_valid_q)
                                             : (last_valid_q - sample_i);
  assign reject = (diff > jump_limit_i) && (last_valid_q != '0);
  assign clean  = reject ? last_valid_q : sample_i;

  // slots not yet written since priming hold the priming sample
  assign oldest   = unfilled ? (primed ? prime_q : sample_i) : rd_data;
  assign sum_base = primed ? sum_q : ({{LOG_D{1'b0}}, sample_i} * DEPTH_S);
  assign sum_d    = sum_base - {{LOG_D{1'b0}}, oldest} + {{LOG_D{1'b0}}, clean};
  assign sum_o    = sum_d;

  assign slot_inc = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  assign slot_d   = adv_i ? slot_inc : slot_q;
  // read one slot ahead so the oldest entry is ready for the next transfer
  assign rd_addr  = slot_d;

  assign last_valid_d = adv_i ? clean : last_valid_q;
  assign prime_d      = (adv_i && !primed) ? sample_i : prime_q;
  assign fill_d       = (adv_i && unfilled) ? fill_q + 1'b1 : fill_q;

  bpd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (adv_i),
    .waddr_i (slot_q),
    .wdata_i (clean),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= '0;
      sum_q        <= '0;
      slot_q       <= '0;
      fill_q       <= '0;
    end else begin
      last_valid_q <= last_valid_d;
      slot_q       <= slot_d;
      fill_q       <= fill_d;
      if (adv_i) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q <= prime_d;
  end

endmodule

>>> rtl/bpd_phase.sv
// exponential smoother, breath phase machine and pump drive
`timescale 1ns / 1ps

module bpd_phase (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic [bpd_pkg::SAMPLE_BITS-1:0] avg_i,
  input  bpd_pkg::cmd_t                  cmd_i,
  input  bpd_pkg::cfg_t                  cfg_i,
  output bpd_pkg::out_item_t             item_o
);

  import bpd_pkg::*;

  localparam int unsigned DIFF_BITS = LEVEL_BITS + 1;
  localparam int unsigned PROD_BITS = DIFF_BITS + ALPHA_BITS + 1;
  localparam int unsigned CMP_BITS  = DIFF_BITS + 1;

  phase_e                 phase_q, phase_d;
  logic [LEVEL_BITS-1:0]  filt_q, filt_d;
  logic [SAMPLE_BITS-1:0] low_q, low_d;

  logic [ALPHA_BITS-1:0]       alpha;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [DIFF_BITS-1:0] slope;
  logic signed [CMP_BITS-1:0]  slope_x, fast_x, slow_x;
  logic [SAMPLE_BITS:0]        rise_lvl;
  logic                        start;

  assign alpha = (phase_q == PH_EXHALED) ? cfg_i.weight_exhaled : cfg_i.weight_other;

  // new = old + floor(alpha * (target - old) / 2^16)
  assign diff  = $signed({1'b0, avg_i, 8'b0}) - $signed({1'b0, filt_q});
  assign prod  = $signed({1'b0, alpha}) * diff;
  assign slope = prod[PROD_BITS-2 -: DIFF_BITS];
  assign filt_d = filt_q + slope[LEVEL_BITS-1:0];

  assign slope_x = {slope[DIFF_BITS-1], slope};
  assign fast_x  = $signed({{(CMP_BITS-SLOPE_BITS){1'b0}}, cfg_i.slope_fast});
  assign slow_x  = $signed({{(CMP_BITS-SLOPE_BITS){1'b0}}, cfg_i.slope_slow});

  always_comb begin
    phase_d  = phase_q;
    low_d    = low_q;
    start    = 1'b0;
    rise_lvl = '0;
    case (phase_q)
      PH_EXHALED: begin
        if (filt_d < {low_q, 8'b0}) begin
          low_d = filt_d[LEVEL_BITS-1 -: SAMPLE_BITS];
        end
        rise_lvl = {1'b0, low_d} + {1'b0, cfg_i.rise_margin};
        if ((slope_x > fast_x) && ({1'b0, filt_d} > {rise_lvl, 8'b0})) begin
          phase_d = PH_INHALING;
          start   = 1'b1;
        end
      end
      PH_INHALING: begin
        if (slope_x < slow_x) begin
          phase_d = PH_INHALED;
        end
      end
      PH_INHALED: begin
        if (slope_x < -fast_x) begin
          phase_d = PH_EXHALING;
        end
      end
      PH_EXHALING: begin
        if (slope_x > -slow_x) begin
          phase_d = PH_EXHALED;
          low_d   = filt_d[LEVEL_BITS-1 -: SAMPLE_BITS];
        end
      end
      default: begin
        phase_d = PH_EXHALED;
      end
    endcase
  end

  always_comb begin
    item_o.average      = avg_i;
    item_o.smoothed     = filt_d;
    item_o.phase        = phase_code(phase_d);
    item_o.pump_on      = cmd_i.force_pump ||
                          (cmd_i.breathe_pump && (phase_d inside {PH_EXHALED, PH_INHALING}));
    item_o.inhale_start = start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EXHALED;
      filt_q  <= '0;
      low_q   <= '1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      filt_q  <= filt_d;
      low_q   <= low_d;
    end
  end

endmodule

>>> rtl/breath_phase_detector.sv
// top level of the breath phase detector: handshake, pipeline and config
// throughput: one sample per cycle while the output is not held; the window
//   sum, the smoother multiply and the phase machine each close their feedback
//   loop within a single stage
// reset: control state, sums, level and phase clear at once; the window ram
//   is not cleared, the first sample after reset primes the whole window
`timescale 1ns / 1ps
`include "breath_phase_detector_macros.svh"

module breath_phase_detector #(
  parameter int unsigned WINDOW_DEPTH = bpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bpd_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bpd_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [bpd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bpd_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  import bpd_pkg::*;

  localparam int unsigned LOG_D    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + LOG_D;
  // reciprocal of the window depth, good to one unit below the quotient
  localparam int unsigned RSHIFT   = SUM_BITS + LOG_D;
  localparam int unsigned PRODW    = SUM_BITS + RSHIFT;
  localparam logic [RSHIFT-1:0]   RECIP   = RSHIFT'((64'd1 << RSHIFT) / WINDOW_DEPTH);
  localparam logic [SUM_BITS-1:0] DEPTH_S = SUM_BITS'(WINDOW_DEPTH);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_exhaled <= WEIGHT_EXHALED_RST;
      cfg_q.weight_other   <= WEIGHT_OTHER_RST;
      cfg_q.jump_limit     <= JUMP_LIMIT_RST;
      cfg_q.rise_margin    <= RISE_MARGIN_RST;
      cfg_q.slope_fast     <= SLOPE_FAST_RST;
      cfg_q.slope_slow     <= SLOPE_SLOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_WEIGHT_EXHALED: cfg_q.weight_exhaled <= cfg_wdata_i;
        CFG_WEIGHT_OTHER:   cfg_q.weight_other   <= cfg_wdata_i;
        CFG_JUMP_LIMIT:     cfg_q.jump_limit     <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_RISE_MARGIN:    cfg_q.rise_margin    <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_SLOPE_FAST:     cfg_q.slope_fast     <= cfg_wdata_i;
        CFG_SLOPE_SLOW:     cfg_q.slope_slow     <= cfg_wdata_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline: s0 input register, s1 window sum, s2 quotient estimate,
  // s3 average, then the output register
  logic v0_q, v1_q, v2_q, v3_q, out_v_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic adv0, adv1, adv2, adv3;

  in_item_t               item0_q;
  cmd_t                   cmd1_q, cmd2_q, cmd3_q;
  logic [SUM_BITS-1:0]    sum1_q, sum2_q;
  logic [SAMPLE_BITS-1:0] quo2_q, avg3_q;
  out_item_t              out_q;

  logic [SUM_BITS-1:0]    sum_next;
  logic [PRODW-1:0]       quo_prod;
  logic [SUM_BITS-1:0]    back_prod, rem2;
  logic [SAMPLE_BITS-1:0] avg_d;
  out_item_t              res_d;

  // a stage takes a new transfer when empty or when it drains the same cycle
  assign rdy_out = !out_v_q || out_ready_i;
  assign rdy3    = !v3_q || rdy_out;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign adv0    = v0_q && rdy1;
  assign adv1    = v1_q && rdy2;
  assign adv2    = v2_q && rdy3;
  assign adv3    = v3_q && rdy_out;

  assign in_ready_o  = rdy0;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_valid_i && rdy0) begin
        v0_q <= 1'b1;
      end else if (adv0) begin
        v0_q <= 1'b0;
      end
      if (adv0) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        v2_q <= 1'b1;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2) begin
        v3_q <= 1'b1;
      end else if (adv3) begin
        v3_q <= 1'b0;
      end
      if (adv3) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // s0: spike rejection and window sum update
  bpd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv0),
    .sample_i     (item0_q.sample),
    .jump_limit_i (cfg_q.jump_limit),
    .sum_o        (sum_next)
  );

  // s1: multiply by the reciprocal of the depth
  assign quo_prod = {{RSHIFT{1'b0}}, sum1_q} * {{SUM_BITS{1'b0}}, RECIP};

  // s2: the estimate is the quotient or one below it, fix with one compare
  assign back_prod = {{LOG_D{1'b0}}, quo2_q} * DEPTH_S;
  assign rem2      = sum2_q - back_prod;
  assign avg_d     = (rem2 >= DEPTH_S) ? quo2_q + 1'b1 : quo2_q;

  // s3: smoother, phase machine and pump
  bpd_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv3),
    .avg_i  (avg3_q),
    .cmd_i  (cmd3_q),
    .cfg_i  (cfg_q),
    .item_o (res_d)
  );

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy0) begin
      item0_q <= in_item_i;
    end
    if (adv0) begin
      sum1_q <= sum_next;
      cmd1_q <= '{force_pump: item0_q.force_pump, breathe_pump: item0_q.breathe_pump};
    end
    if (adv1) begin
      sum2_q <= sum1_q;
      quo2_q <= quo_prod[RSHIFT +: SAMPLE_BITS];
      cmd2_q <= cmd1_q;
    end
    if (adv2) begin
      avg3_q <= avg_d;
      cmd3_q <= cmd2_q;
    end
    if (adv3) begin
      out_q <= res_d;
    end
  end

  // input can only stall when every stage is full and the output is held
  `BPD_ASSERT_IMPL(a_stall_only_when_full, !in_ready_o, v0_q && out_v_q && !out_ready_i)
  // an input transfer always lands in the input register
  `BPD_ASSERT_NEXT(a_transfer_loads_s0, in_valid_i && in_ready_o, v0_q)
  // a result appears only from a filled last stage
  `BPD_ASSERT_NEXT(a_result_from_s3, !out_v_q && !v3_q, !out_valid_o)
  // the reciprocal estimate is never more than one below the quotient
  `BPD_ASSERT_IMPL(a_quotient_close, v2_q, rem2 < (DEPTH_S << 1))

endmodule

>>> tb/breath_phase_detector_tb.sv
// self-checking testbench for the breath phase detector with an in-bench predictor
`timescale 1ns / 1ps

module breath_phase_detector_tb;
  import bpd_pkg::*;

  localparam int unsigned WINDOW       = WINDOW_DEPTH_DEF;
  localparam int          SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  // pause after the last result before touching registers
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // register indexes beyond the six real ones, the block must ignore them
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef enum int {SEG_BOTTOM, SEG_RISE, SEG_TOP, SEG_FALL} wave_seg_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  breath_phase_detector u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the detector and its registers
  // ---------------------------------------------------------------------------
  cfg_t settings = '{
    weight_exhaled: WEIGHT_EXHALED_RST,
    weight_other:   WEIGHT_OTHER_RST,
    jump_limit:     JUMP_LIMIT_RST,
    rise_margin:    RISE_MARGIN_RST,
    slope_fast:     SLOPE_FAST_RST,
    slope_slow:     SLOPE_SLOW_RST
  };

  logic [SAMPLE_BITS-1:0] window_q [WINDOW];
  int unsigned            window_slot = 0;
  int unsigned            window_total = 0;
  logic [SAMPLE_BITS-1:0] last_valid_q = '0;
  logic [LEVEL_BITS-1:0]  level_q = '0;
  logic [SAMPLE_BITS-1:0] low_mark_q = SAMPLE_BITS'(SAMPLE_MAX);
  logic [PHASE_BITS-1:0]  phase_q = PHASE_CODE_EXHALED;
  bit                     window_primed = 1'b0;

  out_item_t   expected_readings [$];
  out_item_t   oldest_reading;
  int unsigned mismatch_count = 0;

  // sender burst state and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  bit          choppy = 1'b0;

  // one sample through the detector: spike reject, boxcar, smoother, phase machine
  function automatic out_item_t next_breath_result(in_item_t item);
    out_item_t              res;
    logic [SAMPLE_BITS-1:0] clean;
    int unsigned            jump;
    int unsigned            mean;
    logic [ALPHA_BITS-1:0]  alpha;
    longint unsigned        a64;
    longint unsigned        mix;
    logic [LEVEL_BITS-1:0]  level_new;
    longint                 slope;
    logic                   started;
    clean = item.sample;
    started = 1'b0;
    // the first sample after reset fills the whole window
    if (!window_primed) begin
      foreach (window_q[k]) window_q[k] = clean;
      window_total = clean * WINDOW;
      window_primed = 1'b1;
    end
    // jump limit, waived while the last kept sample is zero
    jump = (clean > last_valid_q) ? clean - last_valid_q : last_valid_q - clean;
    if (jump > settings.jump_limit && last_valid_q != 0) clean = last_valid_q;
    last_valid_q = clean;
    window_total = window_total - window_q[window_slot] + clean;
    window_q[window_slot] = clean;
    window_slot = (window_slot + 1) % WINDOW;
    mean = window_total / WINDOW;
    // weight picked from the phase before this update, truncated product
    alpha = (phase_q == PHASE_CODE_EXHALED) ? settings.weight_exhaled : settings.weight_other;
    a64 = alpha;
    mix = (a64 * (longint'(mean) << 8) + (65536 - a64) * longint'(level_q)) >> 16;
    level_new = mix[LEVEL_BITS-1:0];
    slope = longint'(level_new) - longint'(level_q);
    case (phase_q)
      PHASE_CODE_EXHALED: begin
        if (longint'(level_new) < (longint'(low_mark_q) << 8)) begin
          low_mark_q = level_new[LEVEL_BITS-1:8];
        end
        if (slope > longint'(settings.slope_fast) &&
            longint'(level_new) >
              ((longint'(low_mark_q) + longint'(settings.rise_margin)) << 8)) begin
          phase_q = PHASE_CODE_INHALING;
          started = 1'b1;
        end
      end
      PHASE_CODE_INHALING: begin
        if (slope < longint'(settings.slope_slow)) phase_q = PHASE_CODE_INHALED;
      end
      PHASE_CODE_INHALED: begin
        if (slope < -longint'(settings.slope_fast)) phase_q = PHASE_CODE_EXHALING;
      end
      default: begin
        if (slope > -longint'(settings.slope_slow)) begin
          phase_q = PHASE_CODE_EXHALED;
          low_mark_q = level_new[LEVEL_BITS-1:8];
        end
      end
    endcase
    level_q = level_new;
    res.average = mean[SAMPLE_BITS-1:0];
    res.smoothed = level_new;
    res.phase = phase_q;
    res.pump_on = item.force_pump | (item.breathe_pump &
                  (phase_q == PHASE_CODE_EXHALED || phase_q == PHASE_CODE_INHALING));
    res.inhale_start = started;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // one sample transfer, with bursts and random gaps in front of it
  task automatic push_reading(logic [SAMPLE_BITS-1:0] value, logic pump_force,
                              logic pump_breathe);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= '{sample: value, force_pump: pump_force, breathe_pump: pump_breathe};
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(next_breath_result(
      '{sample: value, force_pump: pump_force, breathe_pump: pump_breathe}));
    @(negedge clk);
  endtask

  // stop sending, let every result out and give the pipeline time to empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WEIGHT_EXHALED: settings.weight_exhaled = data;
      CFG_WEIGHT_OTHER:   settings.weight_other = data;
      CFG_JUMP_LIMIT:     settings.jump_limit = data[SAMPLE_BITS-1:0];
      CFG_RISE_MARGIN:    settings.rise_margin = data[SAMPLE_BITS-1:0];
      CFG_SLOPE_FAST:     settings.slope_fast = data;
      CFG_SLOPE_SLOW:     settings.slope_slow = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // all six registers; the 12-bit ones get junk in the upper nibble
  task automatic apply_settings(cfg_t s);
    write_cfg(CFG_WEIGHT_EXHALED, s.weight_exhaled);
    write_cfg(CFG_WEIGHT_OTHER, s.weight_other);
    write_cfg(CFG_JUMP_LIMIT, {4'($urandom), s.jump_limit});
    write_cfg(CFG_RISE_MARGIN, {4'($urandom), s.rise_margin});
    write_cfg(CFG_SLOPE_FAST, s.slope_fast);
    write_cfg(CFG_SLOPE_SLOW, s.slope_slow);
  endtask

  // settings in the range where real breathing gets through all four phases
  function automatic cfg_t random_settings();
    cfg_t s;
    s.weight_exhaled = $urandom_range(2000, 40000);
    s.weight_other = $urandom_range(2000, 40000);
    s.jump_limit = $urandom_range(100, 800);
    s.rise_margin = $urandom_range(0, 200);
    s.slope_fast = $urandom_range(256, 3000);
    s.slope_slow = $urandom_range(0, 1000);
    return s;
  endfunction

  // breathing waveform: rise, top plateau, fall, bottom plateau, with noise,
  // spikes, rail values and cut-short segments mixed in
  task automatic drive_breaths(int unsigned n_items);
    wave_seg_e seg;
    int        level;
    int        step;
    int        seg_left;
    int        value;
    seg = SEG_BOTTOM;
    seg_left = $urandom_range(4, 20);
    level = int'(last_valid_q);
    step = 0;
    repeat (n_items) begin
      if (seg_left <= 0 || $urandom_range(0, 59) == 0) begin
        case (seg)
          SEG_BOTTOM: seg = SEG_RISE;
          SEG_RISE:   seg = SEG_TOP;
          SEG_TOP:    seg = SEG_FALL;
          default:    seg = SEG_BOTTOM;
        endcase
        seg_left = (seg == SEG_RISE || seg == SEG_FALL) ? $urandom_range(6, 30)
                                                        : $urandom_range(8, 40);
        step = $urandom_range(8, 160);
      end
      seg_left--;
      if (seg == SEG_RISE) level += step;
      else if (seg == SEG_FALL) level -= step;
      if (level < 0) level = 0;
      if (level > SAMPLE_MAX) level = SAMPLE_MAX;
      value = level + int'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 49))
        0, 1:    value = $urandom_range(0, SAMPLE_MAX);
        2:       value = 0;
        3:       value = SAMPLE_MAX;
        default: ;
      endcase
      if (value < 0) value = 0;
      if (value > SAMPLE_MAX) value = SAMPLE_MAX;
      push_reading(value[SAMPLE_BITS-1:0], $urandom_range(0, 9) == 0,
                   $urandom_range(0, 3) != 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // priming by the first sample, the jump limit at and just past its setting,
  // and every pump command combination
  task automatic test_priming_and_step_limit();
    push_reading(12'd4095, 1'b0, 1'b1);
    push_reading(12'd0, 1'b0, 1'b1);
    push_reading(12'd3795, 1'b0, 1'b0);
    push_reading(12'd3494, 1'b1, 1'b0);
    push_reading(12'd3495, 1'b1, 1'b1);
    push_reading(12'd3495, 1'b0, 1'b0);
    push_reading(12'd3495, 1'b1, 1'b0);
    push_reading(12'd3495, 1'b0, 1'b1);
    push_reading(12'd3495, 1'b1, 1'b1);
    settle_block();
  endtask

  // a kept zero lifts the jump limit for the next sample
  task automatic test_zero_last_valid();
    write_cfg(CFG_JUMP_LIMIT, 16'hFFFF);
    push_reading(12'd0, 1'b0, 1'b1);
    settle_block();
    write_cfg(CFG_JUMP_LIMIT, 16'd100);
    push_reading(12'hAAB, 1'b1, 1'b1);
    push_reading(12'h555, 1'b0, 1'b1);
    push_reading(12'hA47, 1'b0, 1'b0);
    settle_block();
  endtask

  // writes to the spare indexes change nothing, wide data is cut to width
  task automatic test_register_decode();
    write_cfg(CFG_IDX_SPARE_LO, 16'hFFFF);
    write_cfg(CFG_IDX_SPARE_HI, 16'h0000);
    write_cfg(CFG_RISE_MARGIN, 16'hF0FF);
    write_cfg(CFG_JUMP_LIMIT, 16'hF12C);
    push_reading(12'd2500, 1'b0, 1'b1);
    push_reading(12'd2800, 1'b1, 1'b0);
    push_reading(12'd2801, 1'b0, 1'b1);
    settle_block();
  endtask

  // corners of the register space, each with a stretch of breathing
  task automatic test_setting_extremes();
    cfg_t s;
    s = '{weight_exhaled: WEIGHT_EXHALED_RST, weight_other: WEIGHT_OTHER_RST,
          jump_limit: JUMP_LIMIT_RST, rise_margin: RISE_MARGIN_RST,
          slope_fast: SLOPE_FAST_RST, slope_slow: SLOPE_SLOW_RST};
    apply_settings(s);
    drive_breaths(110);
    settle_block();
    // full weight, no jump limit, zero rise margin and zero slope thresholds
    s = '{weight_exhaled: 16'hFFFF, weight_other: 16'hFFFF, jump_limit: 12'hFFF,
          rise_margin: 12'h000, slope_fast: 16'h0000, slope_slow: 16'h0000};
    apply_settings(s);
    drive_breaths(110);
    settle_block();
    // zero weight freezes the level, zero step freezes the samples
    s = '{weight_exhaled: 16'h0000, weight_other: 16'h0000, jump_limit: 12'h000,
          rise_margin: 12'hFFF, slope_fast: 16'hFFFF, slope_slow: 16'hFFFF};
    apply_settings(s);
    drive_breaths(110);
    settle_block();
    // fast while exhaled, frozen elsewhere
    s = '{weight_exhaled: 16'hFFFF, weight_other: 16'h0000, jump_limit: 12'hFFF,
          rise_margin: 12'hFFF, slope_fast: 16'h0000, slope_slow: 16'hFFFF};
    apply_settings(s);
    drive_breaths(110);
    settle_block();
    apply_settings(random_settings());
    drive_breaths(110);
    settle_block();
  endtask

  // long breathing runs under fresh random settings
  task automatic test_random_breathing();
    repeat (5) begin
      apply_settings(random_settings());
      drive_breaths(140);
      settle_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: free-running stretches alternate with choppy ones
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (mode_left == 0) begin
      choppy = $urandom_range(0, 2) != 0;
      mode_left = $urandom_range(30, 200);
    end
    mode_left--;
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (choppy && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking: every result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none actual %p",
                 $time, out_item);
        mismatch_count++;
      end else begin
        oldest_reading = expected_readings.pop_front();
        check_field("average", oldest_reading.average, out_item.average);
        check_field("smoothed", oldest_reading.smoothed, out_item.smoothed);
        check_field("phase", oldest_reading.phase, out_item.phase);
        check_field("pump_on", oldest_reading.pump_on, out_item.pump_on);
        check_field("inhale_start", oldest_reading.inhale_start, out_item.inhale_start);
      end
    end
  end

  // watchdog on a plain cycle count
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_priming_and_step_limit();
    test_zero_last_valid();
    test_register_decode();
    test_setting_extremes();
    test_random_breathing();

    // drain, then watch a while longer for stray results
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
